// ===== rtl/clpd_pkg.sv =====
// shared types and constants of the command/length/payload deframer
`default_nettype none

package clpd_pkg;

   typedef enum logic [1:0] {
      PH_CMD    = 2'd0,
      PH_LEN_LO = 2'd1,
      PH_LEN_HI = 2'd2,
      PH_DATA   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_EMPTY    = 2'd1,
      KIND_BAD_CMD  = 2'd2,
      KIND_OVERLONG = 2'd3
   } kind_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_MIN        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_MAX        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD_LENGTH = 2'd2;

   localparam logic [7:0]  COMMAND_MIN_RESET        = 8'd0;
   localparam logic [7:0]  COMMAND_MAX_RESET        = 8'd255;
   localparam logic [15:0] MAX_PAYLOAD_LENGTH_RESET = 16'd255;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  command;
      logic [15:0] length;
      logic [15:0] byte_index;
      logic [7:0]  data_byte;
      logic        end_of_packet;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/clpd_front.sv =====
// front end: header parsing, command and length checks, result classification
`default_nettype none

module clpd_front (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_push,
   input  wire  [7:0]                          req_byte_in,
   input  wire                                 queue_full,
   input  wire                                 csr_valid,
   input  wire  [clpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [clpd_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                item_valid,
   output clpd_pkg::rsp_item_type              item
);

   clpd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  held_command_ff, held_command_in;
   logic [15:0] held_length_ff, held_length_in;
   logic [15:0] bytes_received_ff, bytes_received_in;
   logic [7:0]  command_min_ff;
   logic [7:0]  command_max_ff;
   logic [15:0] max_payload_length_ff;

   logic        accept;
   logic        bad_cmd;
   logic [15:0] full_length;
   logic        overlong;
   logic        zero_length;
   logic [15:0] next_index;
   logic        last_byte;

   assign accept      = req_push & ~queue_full;
   assign bad_cmd     = (req_byte_in < command_min_ff) || (req_byte_in > command_max_ff);
   assign full_length = {req_byte_in, held_length_ff[7:0]};
   assign overlong    = full_length > max_payload_length_ff;
   assign zero_length = full_length == 16'd0;
   assign next_index  = bytes_received_ff + 16'd1;
   assign last_byte   = next_index == held_length_ff;

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            clpd_pkg::PH_CMD: begin
               phase_in = bad_cmd ? clpd_pkg::PH_CMD : clpd_pkg::PH_LEN_LO;
            end
            clpd_pkg::PH_LEN_LO: begin
               phase_in = clpd_pkg::PH_LEN_HI;
            end
            clpd_pkg::PH_LEN_HI: begin
               phase_in = (overlong || zero_length) ? clpd_pkg::PH_CMD : clpd_pkg::PH_DATA;
            end
            clpd_pkg::PH_DATA: begin
               phase_in = last_byte ? clpd_pkg::PH_CMD : clpd_pkg::PH_DATA;
            end
            default: begin
               phase_in = clpd_pkg::PH_CMD;
            end
         endcase
      end
   end

   // outputs and held header fields
   always_comb begin
      item_valid         = 1'b0;
      item.kind          = clpd_pkg::KIND_PAYLOAD;
      item.command       = held_command_ff;
      item.length        = held_length_ff;
      item.byte_index    = 16'd0;
      item.data_byte     = 8'd0;
      item.end_of_packet = 1'b0;
      held_command_in    = held_command_ff;
      held_length_in     = held_length_ff;
      bytes_received_in  = bytes_received_ff;
      if (accept) begin
         unique case (phase_ff)
            clpd_pkg::PH_CMD: begin
               if (bad_cmd) begin
                  item_valid   = 1'b1;
                  item.kind    = clpd_pkg::KIND_BAD_CMD;
                  item.command = req_byte_in;
                  item.length  = 16'd0;
               end else begin
                  held_command_in = req_byte_in;
               end
               bytes_received_in = 16'd0;
            end
            clpd_pkg::PH_LEN_LO: begin
               held_length_in = {8'd0, req_byte_in};
            end
            clpd_pkg::PH_LEN_HI: begin
               held_length_in    = full_length;
               bytes_received_in = 16'd0;
               if (overlong) begin
                  item_valid  = 1'b1;
                  item.kind   = clpd_pkg::KIND_OVERLONG;
                  item.length = full_length;
               end else if (zero_length) begin
                  item_valid         = 1'b1;
                  item.kind          = clpd_pkg::KIND_EMPTY;
                  item.length        = 16'd0;
                  item.end_of_packet = 1'b1;
               end
            end
            clpd_pkg::PH_DATA: begin
               item_valid         = 1'b1;
               item.kind          = clpd_pkg::KIND_PAYLOAD;
               item.byte_index    = bytes_received_ff;
               item.data_byte     = req_byte_in;
               item.end_of_packet = last_byte;
               bytes_received_in  = last_byte ? 16'd0 : next_index;
            end
            default: begin
               item_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= clpd_pkg::PH_CMD;
         held_command_ff   <= 8'd0;
         held_length_ff    <= 16'd0;
         bytes_received_ff <= 16'd0;
      end else begin
         phase_ff          <= phase_in;
         held_command_ff   <= held_command_in;
         held_length_ff    <= held_length_in;
         bytes_received_ff <= bytes_received_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_min_ff        <= clpd_pkg::COMMAND_MIN_RESET;
         command_max_ff        <= clpd_pkg::COMMAND_MAX_RESET;
         max_payload_length_ff <= clpd_pkg::MAX_PAYLOAD_LENGTH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            clpd_pkg::CSR_COMMAND_MIN:        command_min_ff        <= csr_data[7:0];
            clpd_pkg::CSR_COMMAND_MAX:        command_max_ff        <= csr_data[7:0];
            clpd_pkg::CSR_MAX_PAYLOAD_LENGTH: max_payload_length_ff <= csr_data;
            default: begin
               command_min_ff <= command_min_ff;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/clpd_queue.sv =====
// result queue between front end and output stage
`default_nettype none

module clpd_queue #(
   parameter int DEPTH = 4
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     wr_en,
   input  clpd_pkg::rsp_item_type  wr_item,
   input  wire                     rd_en,
   output clpd_pkg::rsp_item_type  rd_item,
   output logic                    full,
   output logic                    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   clpd_pkg::rsp_item_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_wr;
   logic do_rd;

   assign full    = count_ff == DEPTH_CNT;
   assign empty   = count_ff == '0;
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_item = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/clpd_back.sv =====
// output stage: holds the oldest result until the receiver takes it
`default_nettype none

module clpd_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     queue_empty,
   input  clpd_pkg::rsp_item_type  queue_item,
   output logic                    queue_pop,
   input  wire                     rsp_pop,
   output logic                    rsp_empty,
   output clpd_pkg::rsp_item_type  rsp_item
);

   logic                   out_valid_ff, out_valid_in;
   clpd_pkg::rsp_item_type out_item_ff;

   assign queue_pop = ~queue_empty & (~out_valid_ff | rsp_pop);
   assign rsp_empty = ~out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (queue_pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         out_item_ff <= queue_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/command_length_payload_deframer.sv =====
// top level of the command/length/payload deframer
//
// Bytes enter on the req_ channel (push/full), one per transfer. Packets are
// a command byte, a 16-bit little-endian length and that many payload bytes.
// The front end parses headers and classifies each byte; results (payload
// byte, empty packet, invalid command, overlong packet) go into a small queue
// of QUEUE_DEPTH entries, and an output register presents the oldest result
// on the rsp_ channel (empty/pop). A header byte gives a result only for an
// invalid command, an empty packet or an overlong packet.
// Throughput: one byte per cycle while req_full is low; a result is written
// into the queue at the transfer edge, then loaded into the output register.
// When the receiver stalls, results pile up in the queue and output register;
// req_full rises only once the queue is full.
// The csr_ channel writes command_min (0), command_max (1) and
// max_payload_length (2); it is always ready and should be used while idle.
// Reset (synchronous) returns the parser to the command phase, empties the
// queue and output register, and restores the register defaults.
`default_nettype none

module command_length_payload_deframer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_push,
   output logic                              req_full,
   input  wire  [7:0]                        req_byte_in,
   output logic                              rsp_empty,
   input  wire                               rsp_pop,
   output logic [1:0]                        rsp_kind,
   output logic [7:0]                        rsp_command,
   output logic [15:0]                       rsp_length,
   output logic [15:0]                       rsp_byte_index,
   output logic [7:0]                        rsp_data_byte,
   output logic                              rsp_end_of_packet,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [clpd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [clpd_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic                   item_valid;
   clpd_pkg::rsp_item_type item;
   logic                   queue_full;
   logic                   queue_empty;
   logic                   queue_pop;
   clpd_pkg::rsp_item_type queue_item;
   clpd_pkg::rsp_item_type out_item;

   assign csr_ready = 1'b1;
   assign req_full  = queue_full;

   clpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_byte_in (req_byte_in),
      .queue_full  (queue_full),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .item_valid  (item_valid),
      .item        (item)
   );

   clpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (item_valid),
      .wr_item (item),
      .rd_en   (queue_pop),
      .rd_item (queue_item),
      .full    (queue_full),
      .empty   (queue_empty)
   );

   clpd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_item  (queue_item),
      .queue_pop   (queue_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_item    (out_item)
   );

   assign rsp_kind          = out_item.kind;
   assign rsp_command       = out_item.command;
   assign rsp_length        = out_item.length;
   assign rsp_byte_index    = out_item.byte_index;
   assign rsp_data_byte     = out_item.data_byte;
   assign rsp_end_of_packet = out_item.end_of_packet;

endmodule

`default_nettype wire
